FILE: hw/rtl/gcfe_pkg.sv
package gcfe_pkg;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_EVICT  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam logic REG_FREQ_LIMIT = 1'b0;
  localparam logic REG_GAP_TICKS  = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_SCAN   = 8'b00000010,
    S_SCHK   = 8'b00000100,
    S_UPD    = 8'b00001000,
    S_EVRD   = 8'b00010000,
    S_EVENT  = 8'b00100000,
    S_EVACT  = 8'b01000000,
    S_OUT    = 8'b10000000
  } state_t;

endpackage

FILE: hw/rtl/gapped_clock_freq_eviction.sv
// gapped multi-bit clock replacement over a table of CAPACITY keyed entries
// input channel: in_valid/in_ready with func, obj_key, count_access
// output channel: out_valid/out_ready with hit, evicted_valid, evicted_key,
//   rotated, status; one result word per input word
// configuration: apb port, freq_limit at 0x0, gap_ticks at 0x4
// lookup and insert scan the table one entry a cycle through a single key
//   comparator and memory read port
// evict reads the ring tail and then the entry, through S_EVRD, S_EVENT and S_EVACT
// a full insert, an empty evict or an unused code goes straight from idle to the output state
// one word is in flight at a time; in_ready is high only while idle, so the
//   next word is taken at the earliest in the cycle after the result is taken
// the result is held in an output register until out_ready takes it, and the
//   block stays busy during that stall
// reset (rst, synchronous) empties the table and ring, zeroes the time counter
//   and loads freq_limit 1 and gap_ticks 6; no clearing pass is needed since
//   valid bits are flip-flops
module gapped_clock_freq_eviction
  import gcfe_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int FREQ_BITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [63:0] obj_key,
  input  logic        count_access,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic        evicted_valid,
  output logic [63:0] evicted_key,
  output logic        rotated,
  output logic [1:0]  status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [FREQ_BITS-1:0] FMAX = {FREQ_BITS{1'b1}};
  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

  logic [63:0]          mem_key  [CAPACITY];
  logic [63:0]          mem_time [CAPACITY];
  logic [FREQ_BITS-1:0] mem_freq [CAPACITY];
  logic [AW-1:0]        mem_ring [CAPACITY];
  logic [CAPACITY-1:0]  valid;

  logic [3:0]  freq_limit;
  logic [15:0] gap_ticks;
  logic [AW-1:0] head, tail;
  logic [CW-1:0] count;
  logic [63:0] time_now;

  state_t state;
  func_t  op;
  logic [63:0] key;
  logic counted;
  logic [AW-1:0] idx, found;
  logic scan_last;
  logic [63:0] rd_key, rd_time;
  logic [FREQ_BITS-1:0] rd_freq;
  logic [AW-1:0] rd_ring;
  logic rd_valid;
  logic [FREQ_BITS-1:0] limit;
  logic [63:0] hit_time;
  logic [FREQ_BITS-1:0] hit_freq;
  logic ev_wait;

  always_comb begin
    if ({4'b0, freq_limit} < 8'(FMAX)) limit = FREQ_BITS'(freq_limit);
    else limit = FMAX;
  end

  function automatic logic [AW-1:0] prev(input logic [AW-1:0] p);
    return (p == '0) ? LAST : p - 1'b1;
  endfunction

  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_GAP_TICKS) prdata = {16'b0, gap_ticks};
    else prdata = {28'b0, freq_limit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_limit <= 4'd1;
      gap_ticks <= 16'd6;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_FREQ_LIMIT) freq_limit <= pwdata[3:0];
      else gap_ticks <= pwdata[15:0];
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // registered memory reads at idx
  always_ff @(posedge clk) begin
    rd_key   <= mem_key[idx];
    rd_time  <= mem_time[idx];
    rd_freq  <= mem_freq[idx];
    rd_ring  <= mem_ring[idx];
    rd_valid <= valid[idx];
    scan_last <= (idx == LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      head <= '0;
      tail <= '0;
      count <= '0;
      time_now <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          op <= func_t'(func);
          key <= obj_key;
          counted <= count_access;
          hit <= 1'b0;
          evicted_valid <= 1'b0;
          evicted_key <= '0;
          rotated <= 1'b0;
          status <= ST_OK;
          idx <= '0;
          unique case (func_t'(func))
            FUNC_LOOKUP: begin
              if (count_access) time_now <= time_now + 64'd1;
              state <= S_SCAN;
            end
            FUNC_INSERT: begin
              if (count >= CW'(CAPACITY)) begin
                status <= ST_FULL;
                state <= S_OUT;
              end else state <= S_SCAN;
            end
            FUNC_EVICT: begin
              if (count == '0) begin
                status <= ST_EMPTY;
                state <= S_OUT;
              end else begin
                idx <= tail;
                state <= S_EVRD;
              end
            end
            default: state <= S_OUT;
          endcase
        end
        S_SCAN: begin
          found <= idx;
          state <= S_SCHK;
          if (idx != LAST) idx <= idx + 1'b1;
        end
        S_SCHK: begin
          // compare entry found, which was read last cycle
          if (op == FUNC_LOOKUP ? (rd_valid && rd_key == key) : !rd_valid) begin
            hit_freq <= rd_freq;
            hit_time <= rd_time;
            state <= S_UPD;
          end else if (scan_last) begin
            if (op == FUNC_INSERT) status <= ST_FULL;
            state <= S_OUT;
          end else begin
            found <= idx;
            if (idx != LAST) idx <= idx + 1'b1;
          end
        end
        S_UPD: begin
          if (op == FUNC_LOOKUP) begin
            hit <= 1'b1;
            if (counted && hit_freq < limit &&
                (time_now - hit_time) > {48'b0, gap_ticks}) begin
              mem_freq[found] <= hit_freq + 1'b1;
              mem_time[found] <= time_now;
            end
          end else begin
            mem_key[found] <= key;
            valid[found] <= 1'b1;
            mem_freq[found] <= '0;
            mem_time[found] <= time_now;
            mem_ring[prev(head)] <= found;
            head <= prev(head);
            if (count == '0) tail <= prev(head);
            count <= count + 1'b1;
          end
          state <= S_OUT;
        end
        S_EVRD: state <= S_EVENT;
        S_EVENT: begin
          found <= rd_ring;
          idx <= rd_ring;
          state <= S_EVACT;
        end
        S_EVACT: if (!ev_wait) begin
          state <= S_OUT;
          if (rd_freq == '0) begin
            valid[found] <= 1'b0;
            evicted_valid <= 1'b1;
            evicted_key <= rd_key;
            tail <= prev(tail);
            count <= count - 1'b1;
          end else begin
            mem_freq[found] <= rd_freq - 1'b1;
            mem_ring[prev(head)] <= found;
            head <= prev(head);
            tail <= prev(tail);
            rotated <= 1'b1;
          end
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // the entry read lands in the cycle after idx is set in S_EVENT
  always_ff @(posedge clk) begin
    if (rst) ev_wait <= 1'b0;
    else ev_wait <= (state == S_EVENT);
  end

endmodule
